// ===== rtl/gchg_pkg.sv =====
// Shared constants and result codes for the greedy coin change block.
package gchg_pkg;

  localparam int COIN_IN_BITS  = 16;
  localparam int AMT_BITS      = 20;
  localparam int DIV_CNT_BITS  = $clog2(AMT_BITS);
  localparam int DEF_MAX_COINS = 16;
  localparam int DEF_COIN_BITS = 16;

  localparam logic KIND_STEP    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

// ===== rtl/gchg_in_if.sv =====
// Input channel carrying one coin load item.
interface gchg_in_if import gchg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [COIN_IN_BITS-1:0] coin_value;
  logic [AMT_BITS-1:0]     target_amount;
  logic                    final_coin;

  modport source (output valid, output coin_value, output target_amount,
                  output final_coin, input ready);
  modport sink (input valid, input coin_value, input target_amount,
                input final_coin, output ready);
endinterface

// ===== rtl/gchg_out_if.sv =====
// Output channel carrying one step or summary item.
interface gchg_out_if import gchg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [COIN_IN_BITS-1:0] used_coin;
  logic [AMT_BITS-1:0]     coin_count;
  logic [AMT_BITS-1:0]     remaining;
  logic                    found;
  logic [AMT_BITS-1:0]     total_coins;
  logic                    overflow;
  logic                    last_result;

  modport source (output valid, output kind, output used_coin, output coin_count,
                  output remaining, output found, output total_coins,
                  output overflow, output last_result, input ready);
  modport sink (input valid, input kind, input used_coin, input coin_count,
                input remaining, input found, input total_coins,
                input overflow, input last_result, output ready);
endinterface

// ===== rtl/greedy_coin_change.sv =====
// Greedy coin change engine: sorted coin list and bit-serial divider walk.
//
// Usage: coin denominations arrive on the coins channel, one per item. Each
// nonzero coin is inserted into a descending list in the cycle it is
// accepted; zero coins are ignored, and coins beyond MAX_COINS are dropped
// and flagged. The item with final_coin set also carries target_amount and
// starts the walk. Load items that are not final produce no output item.
// Walk: the list is shifted out head first, one entry at a time. A coin no
// greater than the remaining amount runs a restoring divide, one quotient
// bit per cycle, then emits a step item with the coin, quotient and
// remainder. A summary item (found, total_coins, overflow, last_result)
// closes the run and empties the list.
// The coins channel is not ready during the walk; a new load item waits
// until the summary has been loaded into the output register.
// Stalls: results has a single output register; while the receiver holds
// ready low the walk waits in its emit or summary step. A new load item is
// taken while the last summary still waits to be taken.
// Reset: rst (synchronous) empties the list, clears the overflow flag and
// the output valid; list contents are not cleared.
module greedy_coin_change import gchg_pkg::*; #(
  parameter int MAX_COINS = DEF_MAX_COINS,
  parameter int COIN_BITS = DEF_COIN_BITS
) (
  input  logic        clk,
  input  logic        rst,
  gchg_in_if.sink     coins,
  gchg_out_if.source  results
);

  localparam int CNT_W = $clog2(MAX_COINS + 1);
  localparam int PW    = COIN_BITS + 1;
  // Common width for comparing a coin against the unpaid amount
  localparam int CW    = (COIN_BITS > AMT_BITS) ? COIN_BITS : AMT_BITS;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_PICK = 5'b00010,
    S_DIV  = 5'b00100,
    S_EMIT = 5'b01000,
    S_SUM  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [COIN_BITS-1:0] list [MAX_COINS];
  logic [COIN_BITS-1:0] ins_list [MAX_COINS];
  logic [MAX_COINS-1:0] ge;
  logic [CNT_W-1:0]     coin_total;
  logic                 dropped;

  // Walk datapath
  logic [AMT_BITS-1:0]     rem;
  logic [AMT_BITS-1:0]     total;
  logic [COIN_BITS-1:0]    part;
  logic [AMT_BITS-1:0]     quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  // Output register
  logic                    out_valid;
  logic                    out_kind;
  logic [COIN_IN_BITS-1:0] out_coin;
  logic [AMT_BITS-1:0]     out_count;
  logic [AMT_BITS-1:0]     out_rem;
  logic                    out_found;
  logic [AMT_BITS-1:0]     out_total;
  logic                    out_ovf;
  logic                    out_last;

  logic [COIN_BITS-1:0] coin_in;
  logic                 coin_nz;
  logic                 list_full;
  logic                 take_coin;
  logic [CNT_W-1:0]     total_after;
  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic [COIN_BITS-1:0] head;
  logic                 head_fits;
  logic [PW-1:0]        part_sh;
  logic                 sub_ok;
  logic [PW-1:0]        part_sub;

  assign coin_in     = COIN_BITS'(coins.coin_value);
  assign coin_nz     = coin_in != '0;
  assign list_full   = coin_total == CNT_W'(MAX_COINS);
  assign take_coin   = coin_nz && !list_full;
  assign total_after = coin_total + CNT_W'(take_coin);
  assign coins.ready = state == S_LOAD;
  assign in_acc      = coins.valid && coins.ready;
  assign out_free    = !out_valid || results.ready;
  // Load the output register with a step or the summary
  assign out_load    = out_free && (state == S_EMIT || state == S_SUM);
  assign head        = list[0];
  assign head_fits   = (head != '0) && (CW'(head) <= CW'(rem));

  // Restoring divide step: shift in the next dividend bit, subtract if it fits
  assign part_sh  = {part, quo[AMT_BITS-1]};
  assign sub_ok   = part_sh >= {1'b0, head};
  assign part_sub = part_sh - {1'b0, head};

  // Insertion cells: each entry keeps, takes the new coin, or takes its upper neighbor
  for (genvar i = 0; i < MAX_COINS; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < coin_total) && (list[i] >= coin_in);
    if (i == 0) begin : g_first
      assign ins_list[i] = ge[i] ? list[i] : coin_in;
    end else begin : g_rest
      assign ins_list[i] = ge[i] ? list[i] : (ge[i-1] ? coin_in : list[i-1]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: if (in_acc && coins.final_coin) state_next = S_PICK;
      S_PICK: begin
        if (coin_total == '0) begin
          state_next = S_SUM;
        end else if (head_fits) begin
          state_next = S_DIV;
        end
      end
      S_DIV:  if (div_cnt == '0) state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_PICK;
      S_SUM:  if (out_free) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      coin_total <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            coin_total <= total_after;
            if (coin_nz && list_full) dropped <= 1'b1;
          end
        end
        S_PICK: begin
          if (coin_total != '0 && !head_fits) coin_total <= coin_total - 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            coin_total <= coin_total - 1'b1;
          end
        end
        S_SUM: begin
          if (out_free) begin
            coin_total <= '0;
            dropped    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: list, divider and output payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (in_acc) begin
          if (take_coin) list <= ins_list;
          rem   <= coins.target_amount;
          total <= '0;
        end
      end
      S_PICK: begin
        if (coin_total != '0) begin
          if (head_fits) begin
            part    <= '0;
            quo     <= rem;
            div_cnt <= DIV_CNT_BITS'(AMT_BITS - 1);
          end else begin
            for (int i = 0; i < MAX_COINS - 1; i++) list[i] <= list[i+1];
          end
        end
      end
      S_DIV: begin
        part    <= sub_ok ? part_sub[COIN_BITS-1:0] : part_sh[COIN_BITS-1:0];
        quo     <= {quo[AMT_BITS-2:0], sub_ok};
        div_cnt <= div_cnt - 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_kind  <= KIND_STEP;
          out_coin  <= COIN_IN_BITS'(head);
          out_count <= quo;
          out_rem   <= AMT_BITS'(part);
          out_found <= 1'b0;
          out_total <= '0;
          out_ovf   <= 1'b0;
          out_last  <= 1'b0;
          rem       <= AMT_BITS'(part);
          total     <= total + quo;
          for (int i = 0; i < MAX_COINS - 1; i++) list[i] <= list[i+1];
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_kind  <= KIND_SUMMARY;
          out_coin  <= '0;
          out_count <= '0;
          out_rem   <= rem;
          out_found <= rem == '0;
          out_total <= total;
          out_ovf   <= dropped;
          out_last  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign results.valid       = out_valid;
  assign results.kind        = out_kind;
  assign results.used_coin   = out_coin;
  assign results.coin_count  = out_count;
  assign results.remaining   = out_rem;
  assign results.found       = out_found;
  assign results.total_coins = out_total;
  assign results.overflow    = out_ovf;
  assign results.last_result = out_last;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    coin_total <= CNT_W'(MAX_COINS))
    else $error("coin list count beyond capacity");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |-> quo != '0)
    else $error("step item with zero quotient");

  a_rem_below_coin: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> part < head)
    else $error("divide remainder not below coin");

  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && out_free) |=> (coin_total == '0 && !dropped && out_valid))
    else $error("summary did not empty the list");

endmodule
